// ===== design/sifl_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab index free list: shared package
// Field widths, opcodes, status codes, register indexes and the control word
// format of the microcoded sequencer.
// ----------------------------------------------------------------------------
package sifl_pkg;

	localparam int OP_W      = 2;
	localparam int ADDR_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int USE_W     = 9;
	localparam int COUNT_W   = 9;
	localparam int SIZE_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int PC_W      = 4;

	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE    = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
	localparam logic [SIZE_W-1:0]  SIZE_RESET  = 11'd16;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_FETCH,
		ACT_RD_HEAD,
		ACT_MUL,
		ACT_POP,
		ACT_SUB,
		ACT_DIV_INIT,
		ACT_DIV_STEP,
		ACT_PUSH,
		ACT_RINIT,
		ACT_CHAIN,
		ACT_BOOT_CHAIN,
		ACT_SET_FULL,
		ACT_SET_BAD,
		ACT_EMIT
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_OUT_BUSY,
		C_NOT_ALLOC,
		C_NOT_FREE,
		C_NOT_REINIT,
		C_FULL,
		C_BAD,
		C_DIV_MORE,
		C_CHAIN_MORE,
		C_BOOT_MORE
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t hold;
		cond_t jump;
		pc_t   target;
	} ucode_t;

	typedef struct packed {
		logic no_item;
		logic out_busy;
		logic not_alloc;
		logic not_free;
		logic not_reinit;
		logic full;
		logic bad;
		logic div_more;
		logic chain_more;
		logic boot_more;
	} flags_t;

endpackage

// ===== design/sifl_req_if.sv =====
// ----------------------------------------------------------------------------
// Slab index free list: request channel
// Valid/ready channel that carries one operation item into the block.
// ----------------------------------------------------------------------------
interface sifl_req_if import sifl_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] free_address;

	modport source (output valid, op, free_address, input ready);
	modport sink (input valid, op, free_address, output ready);

endinterface

// ===== design/sifl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Slab index free list: result channel
// Valid/ready channel that carries one result item out of the block.
// ----------------------------------------------------------------------------
interface sifl_rsp_if import sifl_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   object_address;
	logic [USE_W-1:0]    in_use;

	modport source (output valid, status, object_address, in_use, input ready);
	modport sink (input valid, status, object_address, in_use, output ready);

endinterface

// ===== design/sifl_ram.sv =====
// ----------------------------------------------------------------------------
// Slab index free list: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sifl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/sifl_seq.sv =====
// ----------------------------------------------------------------------------
// Slab index free list: microcode sequencer
// Step counter and control store. Each step may hold on one condition and
// otherwise jump on another or fall through to the next step.
// ----------------------------------------------------------------------------
module sifl_seq import sifl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ucode_t uc
);

	localparam pc_t PC_FETCH    = 4'd0;
	localparam pc_t PC_DISPATCH = 4'd1;
	localparam pc_t PC_A_CHECK  = 4'd2;
	localparam pc_t PC_A_POP    = 4'd3;
	localparam pc_t PC_F_SUB    = 4'd4;
	localparam pc_t PC_F_CHECK  = 4'd5;
	localparam pc_t PC_F_DIV    = 4'd6;
	localparam pc_t PC_F_PUSH   = 4'd7;
	localparam pc_t PC_R_CHECK  = 4'd8;
	localparam pc_t PC_R_INIT   = 4'd9;
	localparam pc_t PC_R_CHAIN  = 4'd10;
	localparam pc_t PC_SET_FULL = 4'd11;
	localparam pc_t PC_SET_BAD  = 4'd12;
	localparam pc_t PC_EMIT     = 4'd13;
	localparam pc_t PC_BOOT     = 4'd14;
	localparam pc_t PC_B_CHAIN  = 4'd15;

	pc_t  pc_q;
	pc_t  pc_next;
	logic hold_true;
	logic jump_true;

	function automatic ucode_t rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			PC_FETCH:    w = '{ACT_FETCH, C_NO_ITEM, C_NEVER, PC_FETCH};
			PC_DISPATCH: w = '{ACT_RD_HEAD, C_NEVER, C_NOT_ALLOC, PC_F_SUB};
			PC_A_CHECK:  w = '{ACT_MUL, C_NEVER, C_FULL, PC_SET_FULL};
			PC_A_POP:    w = '{ACT_POP, C_NEVER, C_ALWAYS, PC_EMIT};
			PC_F_SUB:    w = '{ACT_SUB, C_NEVER, C_NOT_FREE, PC_R_CHECK};
			PC_F_CHECK:  w = '{ACT_DIV_INIT, C_NEVER, C_BAD, PC_SET_BAD};
			PC_F_DIV:    w = '{ACT_DIV_STEP, C_DIV_MORE, C_NEVER, PC_FETCH};
			PC_F_PUSH:   w = '{ACT_PUSH, C_NEVER, C_ALWAYS, PC_EMIT};
			PC_R_CHECK:  w = '{ACT_NONE, C_NEVER, C_NOT_REINIT, PC_EMIT};
			PC_R_INIT:   w = '{ACT_RINIT, C_NEVER, C_NEVER, PC_FETCH};
			PC_R_CHAIN:  w = '{ACT_CHAIN, C_CHAIN_MORE, C_ALWAYS, PC_EMIT};
			PC_SET_FULL: w = '{ACT_SET_FULL, C_NEVER, C_ALWAYS, PC_EMIT};
			PC_SET_BAD:  w = '{ACT_SET_BAD, C_NEVER, C_NEVER, PC_FETCH};
			PC_EMIT:     w = '{ACT_EMIT, C_OUT_BUSY, C_ALWAYS, PC_FETCH};
			PC_BOOT:     w = '{ACT_RINIT, C_NEVER, C_NEVER, PC_FETCH};
			PC_B_CHAIN:  w = '{ACT_BOOT_CHAIN, C_BOOT_MORE, C_ALWAYS, PC_FETCH};
			default:     w = '{ACT_NONE, C_NEVER, C_ALWAYS, PC_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic test(input cond_t c, input flags_t f);
		logic r;
		unique case (c)
			C_NEVER:      r = 1'b0;
			C_ALWAYS:     r = 1'b1;
			C_NO_ITEM:    r = f.no_item;
			C_OUT_BUSY:   r = f.out_busy;
			C_NOT_ALLOC:  r = f.not_alloc;
			C_NOT_FREE:   r = f.not_free;
			C_NOT_REINIT: r = f.not_reinit;
			C_FULL:       r = f.full;
			C_BAD:        r = f.bad;
			C_DIV_MORE:   r = f.div_more;
			C_CHAIN_MORE: r = f.chain_more;
			C_BOOT_MORE:  r = f.boot_more;
			default:      r = 1'b0;
		endcase
		return r;
	endfunction

	assign uc        = rom(pc_q);
	assign hold_true = test(uc.hold, flags);
	assign jump_true = test(uc.jump, flags);

	always_comb begin
		if (hold_true) begin
			pc_next = pc_q;
		end else if (jump_true) begin
			pc_next = uc.target;
		end else begin
			pc_next = pc_t'(pc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_BOOT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== design/sifl_datapath.sv =====
// ----------------------------------------------------------------------------
// Slab index free list: datapath
// Configuration registers, free list state, next-index table, shift-subtract
// divider, address multiplier and the output register, all driven by the
// control word of the sequencer.
// ----------------------------------------------------------------------------
module sifl_datapath import sifl_pkg::*; #(
	parameter int MAX_OBJECTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  ucode_t               uc,
	output flags_t               flags,
	sifl_req_if.sink             req,
	sifl_rsp_if.source           rsp
);

	localparam int IW = $clog2(MAX_OBJECTS);
	localparam int CW = $clog2(MAX_OBJECTS + 1);
	localparam int LW = IW + SIZE_W;
	localparam int KW = $clog2(IW + 1);
	localparam logic [IW-1:0] MAX_LAST = IW'(MAX_OBJECTS - 1);

	logic [COUNT_W-1:0]  object_count_q;
	logic [SIZE_W-1:0]   object_size_q;
	logic [ADDR_W-1:0]   data_base_q;

	logic [IW-1:0]       head_q;
	logic                empty_q;
	logic [CW-1:0]       used_q;

	logic [OP_W-1:0]     op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   diff_q;
	logic                lt_q;
	logic [LW-1:0]       lim_q;
	logic [LW-1:0]       rem_q;
	logic [LW-1:0]       dsh_q;
	logic [IW-1:0]       quo_q;
	logic [KW-1:0]       cnt_q;
	logic [IW-1:0]       widx_q;
	logic [LW-1:0]       prod_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   res_addr_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [USE_W-1:0]    out_in_use_q;

	logic [CW-1:0]       n_eff;
	logic [IW-1:0]       n_last;
	logic [LW-1:0]       n_ext;
	logic [LW-1:0]       size_ext;
	logic [LW-1:0]       head_ext;
	logic [IW-1:0]       widx_inc;
	logic                rem_ge;
	logic                accept;
	logic                out_busy;
	logic                emit_fire;

	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [IW-1:0]       ram_wdata;
	logic                ram_re;
	logic [IW-1:0]       ram_rdata;

	always_comb begin
		if (object_count_q == '0) begin
			n_eff = CW'(1);
		end else if (object_count_q > COUNT_W'(MAX_OBJECTS)) begin
			n_eff = CW'(MAX_OBJECTS);
		end else begin
			n_eff = CW'(object_count_q);
		end
	end

	assign n_last    = IW'(n_eff - CW'(1));
	assign n_ext     = LW'(n_eff);
	assign size_ext  = LW'(object_size_q);
	assign head_ext  = LW'(head_q);
	assign widx_inc  = IW'(widx_q + 1'b1);
	assign rem_ge    = (rem_q >= dsh_q);

	assign req.ready = (uc.act == ACT_FETCH);
	assign accept    = req.valid && req.ready;
	assign out_busy  = out_valid_q && !rsp.ready;
	assign emit_fire = (uc.act == ACT_EMIT) && !out_busy;

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.object_address = out_addr_q;
	assign rsp.in_use         = out_in_use_q;

	always_comb begin
		flags.no_item    = !req.valid;
		flags.out_busy   = out_busy;
		flags.not_alloc  = (op_q != OP_ALLOC);
		flags.not_free   = (op_q != OP_FREE);
		flags.not_reinit = (op_q != OP_REINIT);
		flags.full       = (used_q >= n_eff) || empty_q;
		flags.bad        = lt_q || (object_size_q == '0) || (used_q == '0) ||
		                   (diff_q >= ADDR_W'(lim_q));
		flags.div_more   = (cnt_q != '0);
		flags.chain_more = (widx_q != n_last);
		flags.boot_more  = (widx_q != MAX_LAST);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = widx_q;
		ram_wdata = widx_inc;
		case (uc.act)
			ACT_PUSH: begin
				ram_we    = 1'b1;
				ram_waddr = quo_q;
				ram_wdata = empty_q ? quo_q : head_q;
			end
			ACT_CHAIN: begin
				ram_we    = 1'b1;
				ram_wdata = (widx_q == n_last) ? widx_q : widx_inc;
			end
			ACT_BOOT_CHAIN: begin
				ram_we    = 1'b1;
				ram_wdata = (widx_q == MAX_LAST) ? widx_q : widx_inc;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re = (uc.act == ACT_RD_HEAD);

	sifl_ram #(
		.WIDTH(IW),
		.DEPTH(MAX_OBJECTS)
	) u_next_index (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_count_q <= COUNT_RESET;
			object_size_q  <= SIZE_RESET;
			data_base_q    <= '0;
			head_q         <= '0;
			empty_q        <= 1'b0;
			used_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OBJECT_COUNT: object_count_q <= cfg_data[COUNT_W-1:0];
					CFG_OBJECT_SIZE:  object_size_q  <= cfg_data[SIZE_W-1:0];
					CFG_DATA_BASE:    data_base_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			case (uc.act)
				ACT_POP: begin
					if (ram_rdata == head_q) begin
						empty_q <= 1'b1;
					end else begin
						head_q <= ram_rdata;
					end
					used_q <= CW'(used_q + 1'b1);
				end
				ACT_PUSH: begin
					head_q  <= quo_q;
					empty_q <= 1'b0;
					used_q  <= CW'(used_q - 1'b1);
				end
				ACT_RINIT: begin
					head_q  <= '0;
					empty_q <= 1'b0;
					used_q  <= '0;
				end
				default: begin
				end
			endcase
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uc.act)
			ACT_FETCH: begin
				if (accept) begin
					op_q   <= req.op;
					addr_q <= req.free_address;
				end
				res_status_q <= ST_OK;
				res_addr_q   <= '0;
			end
			ACT_MUL: begin
				prod_q <= LW'(head_ext * size_ext);
			end
			ACT_POP: begin
				res_addr_q <= data_base_q + ADDR_W'(prod_q);
			end
			ACT_SUB: begin
				{lt_q, diff_q} <= {1'b0, addr_q} - {1'b0, data_base_q};
				lim_q          <= LW'(n_ext * size_ext);
			end
			ACT_DIV_INIT: begin
				rem_q <= diff_q[LW-1:0];
				dsh_q <= LW'(size_ext << (IW - 1));
				quo_q <= '0;
				cnt_q <= KW'(IW - 1);
			end
			ACT_DIV_STEP: begin
				if (rem_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= IW'({quo_q, rem_ge});
				dsh_q <= dsh_q >> 1;
				cnt_q <= KW'(cnt_q - 1'b1);
			end
			ACT_RINIT: begin
				widx_q <= '0;
			end
			ACT_CHAIN, ACT_BOOT_CHAIN: begin
				widx_q <= widx_inc;
			end
			ACT_SET_FULL: begin
				res_status_q <= ST_FULL;
			end
			ACT_SET_BAD: begin
				res_status_q <= ST_BAD_FREE;
			end
			ACT_EMIT: begin
				if (!out_busy) begin
					out_status_q <= res_status_q;
					out_addr_q   <= res_addr_q;
					out_in_use_q <= USE_W'(used_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/slab_index_free_list.sv =====
// ----------------------------------------------------------------------------
// Slab index free list: top level
// Allocates and frees fixed-size objects of one slab from a linked free list.
// ----------------------------------------------------------------------------
// The req channel takes one item at a time: op 0 allocates, op 1 frees the
// object at free_address, op 2 rebuilds the free list, op 3 does nothing.
// Every item gives exactly one item on the rsp channel with a status, the
// allocated address and the number of objects in use afterwards.
// The registers object_count, object_size and data_base are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while no
// item is in flight, as the block itself does not enforce this.
// A free runs the shift-subtract divider, one quotient bit per cycle, and a
// rebuild chains the table entries of the n configured objects, one entry
// written per cycle.
// req.ready rises again at the same edge that raises rsp.valid.
// After reset the control store chains all MAX_OBJECTS table entries,
// one per cycle, before req.ready first rises.
// The result sits in an output register; an item is still accepted while
// rsp stalls, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module slab_index_free_list import sifl_pkg::*; #(
	parameter int MAX_OBJECTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	sifl_req_if.sink             req,
	sifl_rsp_if.source           rsp
);

	ucode_t uc;
	flags_t flags;

	sifl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uc     (uc)
	);

	sifl_datapath #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.uc        (uc),
		.flags     (flags),
		.req       (req),
		.rsp       (rsp)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("A second item was accepted while one was in flight.");

	assert property (@(posedge clk) disable iff (!arst_n)
		uc.act == ACT_EMIT && !flags.out_busy |=> rsp.valid)
		else $error("A finished result did not reach the output register.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.in_use <= USE_W'(MAX_OBJECTS))
		else $error("The count in use exceeds the slab capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.object_address == '0)
		else $error("A failed item carries a nonzero address.");

endmodule
